FILE: sv/npm_pkg.sv
package npm_pkg;

  localparam int unsigned PatWordW  = 64;
  localparam int unsigned PatLenW   = 6;
  localparam int unsigned StartW    = 16;
  localparam int unsigned TotalW    = 17;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic [1:0] {
    CFG_PATTERN = 2'd0,
    CFG_LEN     = 2'd1,
    CFG_START   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] base_code;
    logic       seq_last;
  } in_word_t;

  typedef struct packed {
    logic              is_match;
    logic [StartW-1:0] match_start;
    logic [TotalW-1:0] match_total;
    logic              is_final;
    logic              pos_overflow;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

endpackage

FILE: sv/npm_window.sv
module npm_window #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned LW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  npm_pkg::win_ctrl_t     ctrl_i,
  input  logic [1:0]             base_i,
  input  logic [npm_pkg::PatWordW-1:0] pattern_i,
  input  logic [LW-1:0]          len_i,
  output logic                   equal_o
);
  import npm_pkg::*;

  localparam int unsigned WW = 2 * MAX_PATTERN;

  logic [WW-1:0]   win_q, win_d;
  logic [WW-1:0]   win_next;
  logic [WW-1:0]   win_al;
  logic [LW-1:0]   diff;
  logic [LW:0]     shamt;
  logic [MAX_PATTERN-1:0] sym_ok;

  // newest symbol enters at the top
  if (MAX_PATTERN == 1) begin : g_one
    assign win_next = base_i;
  end else begin : g_many
    assign win_next = {base_i, win_q[WW-1:2]};
  end

  assign diff   = LW'(MAX_PATTERN) - len_i;
  assign shamt  = {diff, 1'b0};
  assign win_al = win_next >> shamt;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sym_ok[i] = (win_al[2*i +: 2] == pattern_i[2*i +: 2]) || (i >= int'(len_i));
    end
  end

  assign equal_o = &sym_ok;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift) begin
      win_d = win_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

FILE: sv/npm_out_reg.sv
module npm_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  npm_pkg::out_word_t data_i,
  input  logic               stall_i,
  output logic               ready_o,
  output logic               valid_o,
  output npm_pkg::out_word_t data_o
);
  import npm_pkg::*;

  logic      valid_q, valid_d;
  out_word_t data_q;

  // free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/nucleotide_pattern_matcher_core.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i / in_stall_o | in_data_i  (base_code, seq_last)
// out     | output    | out_valid_o / out_stall_i | out_data_o (match, start, total, ...)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One nucleotide per cycle while the output is not stalled: a word is held in the
// input register, the window compare and tracking update run on it there, and the
// result register holds the result for the output if the word is a match or ends
// its sequence, so a result passes the input register and then the result register.
// Reset is asynchronous, active low, and needs no clearing pass. A stall on a full
// output register holds the input register, which then stalls the input.
module nucleotide_pattern_matcher_core #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned MAX_SEQ_LEN = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  npm_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output npm_pkg::out_word_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [npm_pkg::PatWordW-1:0]  cfg_data_i
);
  import npm_pkg::*;

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PW = $clog2(MAX_SEQ_LEN + 1);
  localparam int unsigned NW = (PW > StartW) ? PW : StartW;

  // configuration
  logic [PatWordW-1:0] pattern_q;
  logic [PatLenW-1:0]  len_q;
  logic [StartW-1:0]   sstart_q;

  // input register
  logic     in_vld_q, in_vld_d;
  in_word_t in_q;

  // sequence tracking
  logic [PW-1:0]     pos_q, pos_d;
  logic [NW-1:0]     next_q, next_d;
  logic [TotalW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;

  logic          accept, proc, advance;
  logic [LW-1:0] eff_len;
  logic          in_range, win_eq, hit, emit;
  logic [PW-1:0] seen;
  logic [NW-1:0] start;
  logic [TotalW-1:0] count_upd;
  logic          ovf_upd;
  win_ctrl_t     wctrl;
  out_word_t     res;

  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign proc       = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // clamp the pattern length to 1..MAX_PATTERN
  always_comb begin
    priority if (len_q == '0) begin
      eff_len = LW'(1);
    end else if (len_q > PatLenW'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = LW'(len_q);
    end
  end

  assign in_range = pos_q < PW'(MAX_SEQ_LEN);
  assign seen     = pos_q + PW'(1);
  assign start    = NW'(seen) - NW'(eff_len);
  assign hit      = in_range && (NW'(seen) >= NW'(eff_len)) && win_eq && (start >= next_q);
  assign emit     = hit || in_q.seq_last;

  assign count_upd = (hit && count_q != TotalMax) ? count_q + TotalW'(1) : count_q;
  assign ovf_upd   = ovf_q || !in_range;

  assign wctrl.shift = proc && in_range;
  assign wctrl.clear = proc && in_q.seq_last;

  npm_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (wctrl),
    .base_i    (in_q.base_code),
    .pattern_i (pattern_q),
    .len_i     (eff_len),
    .equal_o   (win_eq)
  );

  always_comb begin
    res.is_match     = hit;
    res.match_start  = hit ? start[StartW-1:0] : '0;
    res.match_total  = count_upd;
    res.is_final     = in_q.seq_last;
    res.pos_overflow = ovf_upd;
  end

  npm_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (proc && emit),
    .data_i  (res),
    .stall_i (out_stall_i),
    .ready_o (advance),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  always_comb begin
    pos_d   = pos_q;
    next_d  = next_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (proc) begin
      if (in_q.seq_last) begin
        pos_d   = '0;
        next_d  = NW'(sstart_q);
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        ovf_d   = ovf_upd;
        count_d = count_upd;
        if (in_range) begin
          pos_d = seen;
        end
        if (hit) begin
          next_d = NW'(seen);
        end
      end
    end else if (cfg_we_i && cfg_idx_i == CFG_START && pos_q == '0) begin
      next_d = NW'(cfg_data_i[StartW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      next_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      next_q  <= next_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= PatLenW'(1);
      sstart_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN: pattern_q <= cfg_data_i;
        CFG_LEN:     len_q     <= cfg_data_i[PatLenW-1:0];
        CFG_START:   sstart_q  <= cfg_data_i[StartW-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_match |-> out_data_o.match_total != '0)
    else $error("match reported with zero total");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.seq_last |=> pos_q == '0 && count_q == '0 && !ovf_q)
    else $error("sequence state not cleared after last word");

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pos_overflow |-> !out_data_o.is_match)
    else $error("match reported past the sequence limit");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_valid_o)
    else $error("input stalled without a held word");
`endif

endmodule
